[rtl/arp_pkg.sv]
// Shared types and constants for the chord tone arpeggiator.
// Holds the beat payloads, status and register codes, and the chord shape table.
// No dependencies.
package arp_pkg;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam logic signed [12:0] OCTAVE_SEMIS = 13'sd12;
    localparam logic signed [12:0] TOP_PITCH = 13'sd127;

    typedef enum logic [2:0] {
        ST_NOTE    = 3'd0,
        ST_REST    = 3'd1,
        ST_BAD_KIND = 3'd2,
        ST_PITCH   = 3'd3,
        ST_CONFIG  = 3'd4,
        ST_ABORT   = 3'd5
    } arp_status_t;

    typedef enum logic [2:0] {
        REG_SEED     = 3'd0,
        REG_STEP     = 3'd1,
        REG_GATE     = 3'd2,
        REG_OCTAVE   = 3'd3,
        REG_VELOCITY = 3'd4,
        REG_CLIP     = 3'd5,
        REG_LIMIT    = 3'd6
    } arp_reg_t;

    typedef enum logic [3:0] {
        KIND_MAJ   = 4'd0,
        KIND_MIN   = 4'd1,
        KIND_DIM   = 4'd2,
        KIND_AUG   = 4'd3,
        KIND_DOM7  = 4'd4,
        KIND_MAJ7  = 4'd5,
        KIND_MIN7  = 4'd6,
        KIND_HDIM7 = 4'd7,
        KIND_SUS2  = 4'd8,
        KIND_SUS4  = 4'd9
    } arp_kind_t;

    typedef struct packed {
        logic       harmony_present;
        logic [3:0] chord_kind;
        logic [6:0] root_offset;
    } arp_step_t;

    typedef struct packed {
        logic        note_valid;
        logic [31:0] start_tick;
        logic [31:0] note_length;
        logic [6:0]  note_pitch;
        logic [15:0] note_level;
        logic [2:0]  status;
        logic        last_step;
    } arp_note_t;

    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][3:0] iv;
    } arp_shape_t;

    function automatic arp_shape_t chord_shape(input logic [3:0] kind);
        arp_shape_t s;
        s.count = 3'd0;
        s.iv = '0;
        unique case (kind)
            KIND_MAJ:   begin s.count = 3'd3; s.iv = {4'd0, 4'd7, 4'd4, 4'd0}; end
            KIND_MIN:   begin s.count = 3'd3; s.iv = {4'd0, 4'd7, 4'd3, 4'd0}; end
            KIND_DIM:   begin s.count = 3'd3; s.iv = {4'd0, 4'd6, 4'd3, 4'd0}; end
            KIND_AUG:   begin s.count = 3'd3; s.iv = {4'd0, 4'd8, 4'd4, 4'd0}; end
            KIND_DOM7:  begin s.count = 3'd4; s.iv = {4'd10, 4'd7, 4'd4, 4'd0}; end
            KIND_MAJ7:  begin s.count = 3'd4; s.iv = {4'd11, 4'd7, 4'd4, 4'd0}; end
            KIND_MIN7:  begin s.count = 3'd4; s.iv = {4'd10, 4'd7, 4'd3, 4'd0}; end
            KIND_HDIM7: begin s.count = 3'd4; s.iv = {4'd10, 4'd6, 4'd3, 4'd0}; end
            KIND_SUS2:  begin s.count = 3'd3; s.iv = {4'd0, 4'd7, 4'd2, 4'd0}; end
            KIND_SUS4:  begin s.count = 3'd3; s.iv = {4'd0, 4'd7, 4'd5, 4'd0}; end
            default:    begin s.count = 3'd0; s.iv = '0; end
        endcase
        return s;
    endfunction

endpackage

[rtl/arp_intf.sv]
// Valid/ready channel interfaces for step beats and note beats.
// Depends on arp_pkg for the payload structs.
interface arp_step_if import arp_pkg::*; ();
    logic      valid;
    logic      ready;
    arp_step_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface arp_note_if import arp_pkg::*; ();
    logic      valid;
    logic      ready;
    arp_note_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/chord_tone_arpeggiator.sv]
// Chord tone arpeggiator: one note beat per step beat, APB register file,
// step-count divider and a two-entry output buffer. Depends on arp_pkg, arp_intf.
// Note beats are registered; the output register plus skid entry decouple stalls.
// Throughput: one step per cycle while the skid entry is empty and the divider idle.
// A write to step_length or clip_length reruns a 32-step restoring divider:
// step_in.ready stays low while the divider loads and runs.
// Reset (rst_n, async, active low) empties the buffer and sets registers to defaults.
module chord_tone_arpeggiator import arp_pkg::*; #(
    parameter int TICK_BITS = 32,
    parameter int MAX_STEPS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    arp_step_if.sink            step_in,
    arp_note_if.source          note_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int CMP_W = (TICK_BITS > 32) ? TICK_BITS : 32;
    localparam logic [32:0] MAX_STEPS_W = 33'(MAX_STEPS);

    function automatic logic [1:0] mod3_64(input logic [63:0] v);
        logic [6:0] acc;
        logic [3:0] fold;
        logic [2:0] f2;
        acc = '0;
        for (int i = 0; i < 32; i++) begin
            acc = acc + 7'(v[2*i +: 2]);
        end
        fold = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[5:4]) + 4'(acc[6]);
        f2 = 3'(fold[1:0]) + 3'(fold[3:2]);
        if (f2 >= 3'd3) begin
            f2 = f2 - 3'd3;
        end
        return f2[1:0];
    endfunction

    // configuration registers
    logic [63:0]       seed_reg;
    logic [1:0]        seed_mod3_reg;
    logic [31:0]       step_length_reg;
    logic [31:0]       gate_length_reg;
    logic signed [7:0] base_octave_reg;
    logic [15:0]       velocity_reg;
    logic [31:0]       clip_length_reg;
    logic [10:0]       note_limit_reg;

    // step state
    logic [31:0]          counter_reg, counter_next;
    logic [1:0]           count_mod3_reg, count_mod3_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic                 error_reg, error_next;

    // divider
    logic        div_load_reg;
    logic        div_active_reg;
    logic [5:0]  div_cnt_reg;
    logic [31:0] div_rem_reg, div_rem_next;
    logic [31:0] div_quo_reg, div_quo_next;
    logic [32:0] div_shift;
    logic        div_bit;
    logic [31:0] last_index_reg;
    logic        busy;

    // output buffer
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    arp_note_t out_data_reg, out_data_next;
    arp_note_t skid_data_reg, skid_data_next;

    logic      cfg_wr;
    arp_reg_t  reg_idx;
    logic      push;
    logic      pop;

    // step datapath
    arp_note_t          result;
    logic               last;
    logic [32:0]        steps;
    logic [32:0]        lim;
    logic               cfg_bad;
    arp_shape_t         shape;
    logic               seed_carry;
    logic [2:0]         mod3_sum;
    logic [1:0]         tone3;
    logic [1:0]         tone4;
    logic [1:0]         tone_idx;
    logic [3:0]         interval;
    logic signed [12:0] oct_ext;
    logic signed [12:0] pitch_s;
    logic [CMP_W-1:0]   tick_ext;
    logic [CMP_W-1:0]   clip_ext;
    logic [31:0]        ticks_left;
    arp_status_t        status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = arp_reg_t'(paddr[5:3]);

    always_comb
    begin
        unique case (reg_idx)
            REG_SEED:     prdata = seed_reg;
            REG_STEP:     prdata = 64'(step_length_reg);
            REG_GATE:     prdata = 64'(gate_length_reg);
            REG_OCTAVE:   prdata = 64'(unsigned'(base_octave_reg));
            REG_VELOCITY: prdata = 64'(velocity_reg);
            REG_CLIP:     prdata = 64'(clip_length_reg);
            REG_LIMIT:    prdata = 64'(note_limit_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= '0;
            seed_mod3_reg   <= '0;
            step_length_reg <= 32'd1;
            gate_length_reg <= 32'd1;
            base_octave_reg <= 8'sd4;
            velocity_reg    <= 16'd100;
            clip_length_reg <= 32'd1;
            note_limit_reg  <= 11'd1024;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_SEED:
                begin
                    seed_reg      <= pwdata;
                    seed_mod3_reg <= mod3_64(pwdata);
                end
                REG_STEP:     step_length_reg <= pwdata[31:0];
                REG_GATE:     gate_length_reg <= pwdata[31:0];
                REG_OCTAVE:   base_octave_reg <= signed'(pwdata[7:0]);
                REG_VELOCITY: velocity_reg    <= pwdata[15:0];
                REG_CLIP:     clip_length_reg <= pwdata[31:0];
                REG_LIMIT:    note_limit_reg  <= pwdata[10:0];
                default:      ;
            endcase
        end
    end

    // step count divider: last index = (clip_length - 1) / step_length
    assign busy      = div_load_reg || div_active_reg;
    assign div_shift = {div_rem_reg, div_quo_reg[31]};
    assign div_bit   = div_shift >= {1'b0, step_length_reg};

    always_comb
    begin
        div_rem_next = div_bit ? 32'(div_shift - {1'b0, step_length_reg}) : div_shift[31:0];
        div_quo_next = {div_quo_reg[30:0], div_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_load_reg   <= 1'b0;
            div_active_reg <= 1'b0;
            div_cnt_reg    <= '0;
            last_index_reg <= '0;
        end
        else
        begin
            div_load_reg <= cfg_wr && (reg_idx == REG_STEP || reg_idx == REG_CLIP);
            if (div_load_reg)
            begin
                div_active_reg <= 1'b1;
                div_cnt_reg    <= 6'd32;
            end
            else if (div_active_reg)
            begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd1)
                begin
                    div_active_reg <= 1'b0;
                    last_index_reg <= (step_length_reg == '0 || clip_length_reg == '0)
                                      ? '0 : div_quo_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load_reg)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= clip_length_reg - 32'd1;
        end
        else if (div_active_reg)
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
        end
    end

    // step result
    always_comb
    begin
        steps   = {1'b0, last_index_reg} + 33'd1;
        lim     = (33'(note_limit_reg) < MAX_STEPS_W) ? 33'(note_limit_reg) : MAX_STEPS_W;
        last    = counter_reg >= last_index_reg;
        cfg_bad = step_length_reg == '0 || gate_length_reg == '0
                  || gate_length_reg > step_length_reg
                  || base_octave_reg < -8'sd1 || base_octave_reg > 8'sd7
                  || velocity_reg == '0 || clip_length_reg == '0
                  || note_limit_reg == '0 || steps > lim;

        shape      = chord_shape(step_in.data.chord_kind);
        seed_carry = 64'(counter_reg) > ~seed_reg;
        mod3_sum   = 3'(seed_mod3_reg) + 3'(count_mod3_reg) + (seed_carry ? 3'd2 : 3'd0);
        priority if (mod3_sum >= 3'd6)
            tone3 = 2'(mod3_sum - 3'd6);
        else if (mod3_sum >= 3'd3)
            tone3 = 2'(mod3_sum - 3'd3);
        else
            tone3 = mod3_sum[1:0];
        tone4    = seed_reg[1:0] + counter_reg[1:0];
        tone_idx = (shape.count == 3'd4) ? tone4 : tone3;
        interval = shape.iv[tone_idx];

        oct_ext = 13'(base_octave_reg);
        pitch_s = (oct_ext + 13'sd1) * OCTAVE_SEMIS
                  + $signed({6'b0, step_in.data.root_offset})
                  + $signed({9'b0, interval});

        tick_ext   = CMP_W'(tick_reg);
        clip_ext   = CMP_W'(clip_length_reg);
        ticks_left = (tick_ext < clip_ext) ? 32'(clip_ext - tick_ext) : '0;

        result = '0;
        priority if (error_reg)
            status = ST_ABORT;
        else if (cfg_bad)
            status = ST_CONFIG;
        else if (!step_in.data.harmony_present)
        begin
            status = ST_REST;
            result.start_tick = 32'(tick_ext);
        end
        else if (shape.count == 3'd0)
            status = ST_BAD_KIND;
        else if (pitch_s < 13'sd0 || pitch_s > TOP_PITCH)
            status = ST_PITCH;
        else
        begin
            status = ST_NOTE;
            result.note_valid  = 1'b1;
            result.start_tick  = 32'(tick_ext);
            result.note_length = (gate_length_reg < ticks_left) ? gate_length_reg : ticks_left;
            result.note_pitch  = pitch_s[6:0];
            result.note_level  = velocity_reg;
        end
        result.status    = status;
        result.last_step = last;
    end

    // state advance
    assign step_in.ready = !skid_valid_reg && !busy;
    assign push = step_in.valid && step_in.ready;
    assign pop  = out_valid_reg && note_out.ready;

    always_comb
    begin
        counter_next    = counter_reg;
        count_mod3_next = count_mod3_reg;
        tick_next       = tick_reg;
        error_next      = error_reg;
        if (push)
        begin
            if (last)
            begin
                counter_next    = '0;
                count_mod3_next = '0;
                tick_next       = '0;
                error_next      = 1'b0;
            end
            else
            begin
                counter_next    = counter_reg + 32'd1;
                count_mod3_next = (count_mod3_reg == 2'd2) ? 2'd0 : count_mod3_reg + 2'd1;
                tick_next       = tick_reg + TICK_BITS'(step_length_reg);
                error_next      = error_reg || status == ST_BAD_KIND
                                  || status == ST_PITCH || status == ST_CONFIG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            count_mod3_reg <= '0;
            tick_reg       <= '0;
            error_reg      <= 1'b0;
        end
        else
        begin
            counter_reg    <= counter_next;
            count_mod3_reg <= count_mod3_next;
            tick_reg       <= tick_next;
            error_reg      <= error_next;
        end
    end

    // output register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = result;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = result;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign note_out.valid = out_valid_reg;
    assign note_out.data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_clip_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && last) |=> (counter_reg == '0 && tick_reg == '0 && !error_reg))
        else $error("state not cleared after last step");

    a_error_no_note: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != ST_NOTE)
        |-> (!out_data_reg.note_valid && out_data_reg.note_length == '0))
        else $error("note fields set on a non-note beat");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        div_active_reg |-> !push)
        else $error("step accepted while step count is stale");

endmodule
